// ----- rtl/core/tcc_pkg.sv -----
package tcc_pkg;

  // Buffer sizing
  localparam int MaxCmdBytes = 64;
  localparam int AddrW       = $clog2(MaxCmdBytes);
  localparam int CountW      = $clog2(MaxCmdBytes + 1);
  localparam int LenW        = 7;

  // Telnet command codes
  localparam logic [7:0] CodeSe   = 8'd240;
  localparam logic [7:0] CodeNop  = 8'd241;
  localparam logic [7:0] CodeGa   = 8'd249;
  localparam logic [7:0] CodeSb   = 8'd250;
  localparam logic [7:0] CodeWill = 8'd251;
  localparam logic [7:0] CodeDont = 8'd254;
  localparam logic [7:0] CodeIac  = 8'd255;

  typedef enum logic [1:0] {
    OpPush  = 2'd0,
    OpClear = 2'd1,
    OpRead  = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef struct packed {
    op_e        opcode;
    logic [7:0] data_byte;
    logic [5:0] read_index;
  } cmd_in_t;

  typedef struct packed {
    logic            accepted;
    logic            command_ready;
    logic [LenW-1:0] command_length;
    logic [7:0]      read_data;
  } cmd_out_t;

  // Status carried from the update stage to the result stage
  typedef struct packed {
    logic              accepted;
    logic              ready;
    logic [CountW-1:0] fill;
    logic              rd_ok;
  } stage_meta_t;

  function automatic logic is_two_byte(input logic [7:0] c);
    return (c == CodeIac) || (c >= CodeNop && c <= CodeGa);
  endfunction

  function automatic logic is_option(input logic [7:0] c);
    return (c >= CodeWill) && (c <= CodeDont);
  endfunction

endpackage

// ----- rtl/core/tcc_ram.sv -----
module tcc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/telnet_command_collector.sv -----
// Each result passes through the read stage and then the output register.
// Throughput: one item per cycle when not stalled; the fill count, ready
// flag and last-byte register are updated in the accept cycle, so the next
// item sees them. Two result slots (read stage and output register) let one
// item enter while a result waits. Reset clears counters, flags and valids;
// the buffer memory is not cleared and reads only below the fill count.
module telnet_command_collector (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcc_pkg::cmd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcc_pkg::cmd_out_t out_data_o
);

  logic                       in_accept;
  logic [tcc_pkg::CountW-1:0] fill_q, fill_d;
  logic                       ready_q, ready_d;
  logic [7:0]                 last_q, last_d;
  logic                       acc;
  logic                       we;
  logic                       re;
  logic                       rd_ok;
  logic [7:0]                 ram_rdata;
  logic                       s1_valid_q;
  logic                       s1_adv;
  tcc_pkg::stage_meta_t       s1_meta_q, s1_meta_d;
  logic                       out_valid_q;
  tcc_pkg::cmd_out_t          out_data_q, out_data_d;

  // Handshake: stall when the read stage is full and cannot advance
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Command state update
  always_comb begin
    fill_d  = fill_q;
    ready_d = ready_q;
    last_d  = last_q;
    acc     = 1'b0;
    we      = 1'b0;
    rd_ok   = 1'b0;
    re      = 1'b0;
    if (in_accept) begin
      case (in_data_i.opcode)
        tcc_pkg::OpPush: begin
          if (!ready_q) begin
            if (fill_q == '0) begin
              if (in_data_i.data_byte == tcc_pkg::CodeIac) begin
                acc    = 1'b1;
                we     = 1'b1;
                fill_d = tcc_pkg::CountW'(1);
                last_d = in_data_i.data_byte;
              end
            end else if (int'(fill_q) >= tcc_pkg::MaxCmdBytes) begin
              // full buffer: drop the byte and restart
              acc     = 1'b1;
              fill_d  = '0;
              ready_d = 1'b0;
            end else begin
              acc    = 1'b1;
              we     = 1'b1;
              fill_d = fill_q + tcc_pkg::CountW'(1);
              last_d = in_data_i.data_byte;
              if (fill_q == tcc_pkg::CountW'(1)) begin
                if (tcc_pkg::is_two_byte(in_data_i.data_byte)) begin
                  ready_d = 1'b1;
                end else if (!tcc_pkg::is_option(in_data_i.data_byte) &&
                             in_data_i.data_byte != tcc_pkg::CodeSb) begin
                  fill_d = '0;
                end
              end else if (fill_q == tcc_pkg::CountW'(2)) begin
                if (tcc_pkg::is_option(last_q)) begin
                  ready_d = 1'b1;
                end else if (last_q != tcc_pkg::CodeSb) begin
                  fill_d = '0;
                end
              end else if (last_q == tcc_pkg::CodeIac &&
                           in_data_i.data_byte == tcc_pkg::CodeSe) begin
                ready_d = 1'b1;
              end
            end
          end
        end
        tcc_pkg::OpClear: begin
          fill_d  = '0;
          ready_d = 1'b0;
        end
        tcc_pkg::OpRead: begin
          re    = 1'b1;
          rd_ok = (int'(in_data_i.read_index) < int'(fill_q)) &&
                  (int'(in_data_i.read_index) < tcc_pkg::MaxCmdBytes);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      ready_q <= 1'b0;
      last_q  <= '0;
    end else begin
      fill_q  <= fill_d;
      ready_q <= ready_d;
      last_q  <= last_d;
    end
  end

  // Command buffer
  tcc_ram #(
    .Width (8),
    .Depth (tcc_pkg::MaxCmdBytes)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (fill_q[tcc_pkg::AddrW-1:0]),
    .wdata_i (in_data_i.data_byte),
    .re_i    (re),
    .raddr_i (tcc_pkg::AddrW'(in_data_i.read_index)),
    .rdata_o (ram_rdata)
  );

  // Read stage: hold status alongside the memory read
  always_comb begin
    s1_meta_d.accepted = acc;
    s1_meta_d.ready    = ready_d;
    s1_meta_d.fill     = fill_d;
    s1_meta_d.rd_ok    = rd_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_accept;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_meta_q <= s1_meta_d;
    end
  end

  // Output register
  always_comb begin
    out_data_d.accepted       = s1_meta_q.accepted;
    out_data_d.command_ready  = s1_meta_q.ready;
    out_data_d.command_length = tcc_pkg::LenW'(s1_meta_q.fill);
    out_data_d.read_data      = s1_meta_q.rd_ok ? ram_rdata : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A waiting command always holds at least IAC and one code byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (fill_q >= tcc_pkg::CountW'(2)))
    else $error("ready flag set with short buffer");

  // Fill count never passes the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= tcc_pkg::MaxCmdBytes)
    else $error("fill count beyond buffer depth");

  // A push while a command waits leaves the state alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.opcode == tcc_pkg::OpPush && ready_q)
      |=> (ready_q && $stable(fill_q)))
    else $error("refused push changed collector state");

endmodule

// ----- bench/tcc_result_checker.sv -----
module tcc_result_checker
  import tcc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  cmd_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  cmd_out_t out_data_i,
  output int       errors_o,
  output int       pending_o,
  output int       checked_o,
  output int       commands_o,
  output int       overflows_o
);

  // Shadow copy of the collector state
  logic [7:0]  cmd_mem [MaxCmdBytes];
  int unsigned fill_cnt;
  logic        shadow_ready;

  cmd_out_t expected_results [$];
  cmd_out_t exp_r;

  // Advance the shadow state by one input beat and return the status it produces
  function automatic cmd_out_t predict_collector(input cmd_in_t c);
    cmd_out_t   r;
    logic [7:0] b;
    logic [7:0] prev;
    r = '0;
    b = c.data_byte;
    case (c.opcode)
      OpPush: begin
        if (shadow_ready) begin
          r.accepted = 1'b0;
        end else if (fill_cnt == 0) begin
          // Only IAC opens a command
          if (b == CodeIac) begin
            cmd_mem[0] = b;
            fill_cnt   = 1;
            r.accepted = 1'b1;
          end
        end else begin
          r.accepted = 1'b1;
          if (fill_cnt >= MaxCmdBytes) begin
            // Full buffer: drop the byte and start over
            fill_cnt = 0;
            overflows_o++;
          end else if (fill_cnt == 1) begin
            cmd_mem[1] = b;
            fill_cnt   = 2;
            if (b == CodeIac || (b >= CodeNop && b <= CodeGa)) begin
              shadow_ready = 1'b1;
            end else if (!(b >= CodeWill && b <= CodeDont) && b != CodeSb) begin
              fill_cnt = 0;
            end
          end else if (fill_cnt == 2) begin
            prev       = cmd_mem[1];
            cmd_mem[2] = b;
            fill_cnt   = 3;
            if (prev >= CodeWill && prev <= CodeDont) begin
              shadow_ready = 1'b1;
            end else if (prev != CodeSb) begin
              fill_cnt = 0;
            end
          end else begin
            // Subnegotiation ends on IAC SE as the last two bytes
            cmd_mem[fill_cnt] = b;
            fill_cnt++;
            if (cmd_mem[fill_cnt - 2] == CodeIac && b == CodeSe) begin
              shadow_ready = 1'b1;
            end
          end
          if (shadow_ready) begin
            commands_o++;
          end
        end
      end
      OpClear: begin
        fill_cnt     = 0;
        shadow_ready = 1'b0;
      end
      OpRead: begin
        if (c.read_index < fill_cnt) begin
          r.read_data = cmd_mem[c.read_index];
        end
      end
      default: ;
    endcase
    r.command_ready  = shadow_ready;
    r.command_length = fill_cnt[LenW-1:0];
    return r;
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt     = 0;
      shadow_ready = 1'b0;
      expected_results.delete();
      errors_o    = 0;
      pending_o   = 0;
      checked_o   = 0;
      commands_o  = 0;
      overflows_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(predict_collector(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (expected_results.size() == 0) begin
          if (errors_o < 10) begin
            $display("%0t: result beat with nothing expected: acc=%0d rdy=%0d len=%0d rd=%02h",
                     $time, out_data_i.accepted, out_data_i.command_ready,
                     out_data_i.command_length, out_data_i.read_data);
          end
          errors_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_i.accepted !== exp_r.accepted ||
              out_data_i.command_ready !== exp_r.command_ready ||
              out_data_i.command_length !== exp_r.command_length ||
              out_data_i.read_data !== exp_r.read_data) begin
            if (errors_o < 10) begin
              $display("%0t: mismatch: expected acc=%0d rdy=%0d len=%0d rd=%02h",
                       $time, exp_r.accepted, exp_r.command_ready,
                       exp_r.command_length, exp_r.read_data);
              $display("%0t:           got      acc=%0d rdy=%0d len=%0d rd=%02h",
                       $time, out_data_i.accepted, out_data_i.command_ready,
                       out_data_i.command_length, out_data_i.read_data);
            end
            errors_o++;
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
module tb;
  import tcc_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldOff    = 64;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  cmd_in_t  in_data   = '0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cmd_out_t out_data;

  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  logic hold_go        = 1'b0;
  int   beats_sent     = 0;
  int   quiet_cycles   = 0;

  int errors;
  int pending;
  int checked;
  int commands;
  int overflows;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  telnet_command_collector u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  tcc_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .commands_o  (commands),
    .overflows_o (overflows)
  );

  // Receiver: random stall, or a counted hold-off when one is requested
  initial begin
    int   hold_left;
    logic hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_taken) begin
        hold_left  = HoldOff;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // Watchdog: end the run after too long without any beat
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no beat for %0d cycles, %0d results pending",
                 QuietLimit, pending);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Offer one beat, with random idle cycles ahead of it, and hold it until taken
  task automatic send_op(input op_e op, input logic [7:0] b, input logic [5:0] idx);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, data_byte: b, read_index: idx};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    beats_sent++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    send_op(OpPush, b, 6'($urandom));
  endtask

  task automatic read_at(input logic [5:0] idx);
    send_op(OpRead, 8'($urandom), idx);
  endtask

  task automatic clear_cmd();
    send_op(OpClear, 8'($urandom), 6'($urandom));
  endtask

  // Read back a few positions, mostly near the front of the buffer
  task automatic read_some();
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(3) == 0) read_at(6'($urandom));
      else read_at(6'($urandom_range(0, 7)));
    end
  endtask

  // Inspect the command, then usually hand it back with a clear
  task automatic wrap_up();
    read_some();
    if ($urandom_range(9) < 8) clear_cmd();
  endtask

  // Open a subnegotiation and fill it with non-IAC bytes until the buffer overflows
  task automatic overflow_seq();
    push_byte(CodeIac);
    push_byte(CodeSb);
    repeat (MaxCmdBytes - 2) push_byte(8'($urandom_range(0, 254)));
    push_byte(8'($urandom));
    read_some();
  endtask

  // One random stream fragment: mostly well-formed commands, some broken, some noise
  task automatic random_sequence();
    int kind;
    kind = $urandom_range(99);
    if (kind < 20) begin
      push_byte(CodeIac);
      if ($urandom_range(9) == 0) push_byte(CodeIac);
      else push_byte(8'($urandom_range(CodeNop, CodeGa)));
      if ($urandom_range(3) == 0) push_byte(8'($urandom));
      wrap_up();
    end else if (kind < 38) begin
      push_byte(CodeIac);
      push_byte(8'($urandom_range(CodeWill, CodeDont)));
      push_byte(8'($urandom));
      wrap_up();
    end else if (kind < 58) begin
      push_byte(CodeIac);
      push_byte(CodeSb);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(4) == 0) push_byte(CodeIac);
        else push_byte(8'($urandom));
      end
      push_byte(CodeIac);
      push_byte(CodeSe);
      wrap_up();
    end else if (kind < 61) begin
      overflow_seq();
    end else if (kind < 71) begin
      push_byte(CodeIac);
      push_byte(8'($urandom_range(0, CodeSe)));
      read_some();
    end else if (kind < 81) begin
      // Subnegotiation abandoned part way
      push_byte(CodeIac);
      push_byte(CodeSb);
      repeat ($urandom_range(0, 4)) push_byte(8'($urandom));
      read_some();
      clear_cmd();
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_op(op_e'($urandom_range(0, 3)), 8'($urandom), 6'($urandom));
      end
    end
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int n_beats);
    int start;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start          = beats_sent;
    while (beats_sent - start < n_beats) random_sequence();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty buffer: read, ignored bytes, idle opcode
    read_at(6'd0);
    push_byte(8'h00);
    push_byte(8'hFE);
    send_op(OpNone, 8'hFF, 6'h3F);
    // Two-byte command, refused push while it waits, reads in and past range
    push_byte(CodeIac);
    push_byte(CodeNop);
    push_byte(CodeIac);
    read_at(6'd0);
    read_at(6'd1);
    read_at(6'h3F);
    clear_cmd();
    // Unknown code after IAC restarts the search
    push_byte(CodeIac);
    push_byte(8'h00);
    // Option command completes on the third byte
    push_byte(CodeIac);
    push_byte(CodeWill);
    push_byte(8'hFF);
    clear_cmd();
    // Subnegotiation ending on IAC SE
    push_byte(CodeIac);
    push_byte(CodeSb);
    push_byte(8'h18);
    push_byte(CodeIac);
    push_byte(CodeSe);
    read_at(6'd4);
    clear_cmd();
    // Escaped IAC as a two-byte command
    push_byte(CodeIac);
    push_byte(CodeIac);
    clear_cmd();

    // Random phases over the idle mixes
    overflow_seq();
    run_phase(0, 0, 40);
    run_phase(57, 0, 110);
    run_phase(0, 57, 110);
    run_phase(18, 18, 110);
    // Long receiver hold-off while the sender keeps offering beats
    hold_go = 1'b1;
    run_phase(0, 0, 80);

    in_valid       <= 1'b0;
    sink_stall_pct  = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Drove %0d input beats across four idle mixes and a %0d-cycle output hold-off.",
             beats_sent, HoldOff);
    $display("Checked %0d result beats; %0d commands completed, %0d buffer overflows.",
             checked, commands, overflows);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results still pending", errors, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
